[hw/rtl/i2c_register_transfer_sequencer_unit_defines.svh]
// Assertion macros shared by the register transfer sequencer RTL.
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IRTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/irts_pkg.sv]
// Shared types and constants for the register transfer sequencer.
`default_nettype none
package irts_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  localparam logic [2:0] KIND_WRITE16 = 3'd0;
  localparam logic [2:0] KIND_READ16  = 3'd1;
  localparam logic [2:0] KIND_WRITE8  = 3'd2;
  localparam logic [2:0] KIND_READ8   = 3'd3;
  localparam logic [2:0] KIND_BLOCK16 = 3'd4;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  localparam logic [1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [1:0] REG_RETRY       = 2'd1;
  localparam logic [1:0] REG_RETRY_SHORT = 2'd2;
  localparam logic [1:0] REG_BLOCK_CMD   = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd10000;
  localparam logic [7:0]  RETRY_RESET       = 8'd4;
  localparam logic [7:0]  RETRY_SHORT_RESET = 8'd20;
  localparam logic [7:0]  BLOCK_CMD_RESET   = 8'h01;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  transfer_kind;
    logic [6:0]  slave_address;
    logic [15:0] register_address;
    logic [7:0]  byte_count;
    logic [7:0]  load_index;
    logic [7:0]  load_byte;
    logic        ack_seen;
    logic [7:0]  bus_read_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] command_byte;
    logic       read_valid;
    logic [7:0] read_value;
    logic [7:0] read_position;
    logic       finished;
    logic       succeeded;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/irts_wbuf.sv]
// Write data buffer: one write port, one registered read port.
`default_nettype none
module irts_wbuf
  import irts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [BUF_AW-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [BUF_AW-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/i2c_register_transfer_sequencer_unit.sv]
// Top level of the I2C register transfer sequencer.
// Use: drive item (request, load write byte, byte engine done, tick) with
// item_valid; an item is taken at a clock edge with item_valid high and
// item_stall low. Each item is handled in the cycle it is taken and its
// result, if any, appears in the result register on the next cycle; one
// item is taken per cycle while item_stall is low. Loads, ticks and ignored
// requests or dones give no result. The result register holds its transfer
// while result_stall is high; item_stall then rises only while a result is
// waiting and stalled, so the next item is taken as soon as the result is
// taken in the same cycle. Data bytes for writes come from a 256-entry
// buffer read through a registered port addressed by the next byte position.
// Configuration goes through the APB port (timeout, retry limits, block read
// command at 0x0, 0x4, 0x8, 0xC); the user writes it only while the block is
// idle (not enforced). Reset (rst, synchronous) returns the sequencer to idle,
// empties the result register, restores register defaults, keeps the buffer.
`default_nettype none
`include "i2c_register_transfer_sequencer_unit_defines.svh"
module i2c_register_transfer_sequencer_unit
  import irts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    P_IDLE, P_START, P_ADDR_W, P_CMD, P_REG_HI, P_REG_LO,
    P_DATA, P_RESTART, P_ADDR_R, P_READ, P_STOP
  } phase_t;

  logic [15:0] timeout_ticks;
  logic [7:0]  retry_limit;
  logic [7:0]  retry_limit_short_read;
  logic [7:0]  block_read_command;

  phase_t      phase, phase_next;
  logic [2:0]  current_kind, current_kind_next;
  logic [6:0]  target_address, target_address_next;
  logic [15:0] target_register, target_register_next;
  logic [7:0]  transfer_length, transfer_length_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  attempts_left, attempts_left_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic        attempt_failed, attempt_failed_next;

  result_t     res, res_next;
  logic        res_from_buf, res_from_buf_next;
  logic        res_next_valid;
  logic        accept;
  logic        cfg_write;
  logic        buf_wr_en;
  logic [7:0]  buf_q;
  logic [BUF_AW-1:0] buf_rd_addr;

  assign accept    = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_TIMEOUT:     prdata = {16'd0, timeout_ticks};
      REG_RETRY:       prdata = {24'd0, retry_limit};
      REG_RETRY_SHORT: prdata = {24'd0, retry_limit_short_read};
      REG_BLOCK_CMD:   prdata = {24'd0, block_read_command};
      default:         prdata = '0;
    endcase
  end

  function automatic logic [7:0] phase_byte(phase_t p, logic [6:0] adr, logic [15:0] rg,
                                            logic [7:0] bc);
    logic [7:0] b;
    b = 8'd0;
    case (p)
      P_ADDR_W: b = {adr, 1'b0};
      P_CMD:    b = bc;
      P_REG_HI: b = rg[15:8];
      P_REG_LO: b = rg[7:0];
      P_ADDR_R: b = {adr, 1'b1};
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

  always_comb begin
    logic        do_try;
    logic        do_read;
    phase_t      tp;
    logic [15:0] te;
    logic [7:0]  pos_inc;
    logic        is_write;

    phase_next           = phase;
    current_kind_next    = current_kind;
    target_address_next  = target_address;
    target_register_next = target_register;
    transfer_length_next = transfer_length;
    byte_position_next   = byte_position;
    attempts_left_next   = attempts_left;
    elapsed_ticks_next   = elapsed_ticks;
    attempt_failed_next  = attempt_failed;
    res_next             = '0;
    res_next_valid       = 1'b0;
    res_from_buf_next    = 1'b0;
    do_try               = 1'b0;
    do_read              = 1'b0;
    tp                   = phase;
    te                   = elapsed_ticks;
    pos_inc              = byte_position + 8'd1;
    is_write = (current_kind == KIND_WRITE16) || (current_kind == KIND_WRITE8);

    case (item.action)
      ACT_REQUEST: begin
        if (phase == P_IDLE && item.transfer_kind <= KIND_BLOCK16) begin
          current_kind_next    = item.transfer_kind;
          target_address_next  = item.slave_address;
          target_register_next = item.register_address;
          transfer_length_next = item.byte_count;
          if (item.transfer_kind != KIND_WRITE16 && item.transfer_kind != KIND_WRITE8
              && item.byte_count == 8'd0) begin
            transfer_length_next = 8'd1;
          end
          attempts_left_next = (item.transfer_kind == KIND_READ8) ?
                               retry_limit_short_read : retry_limit;
          phase_next          = P_START;
          attempt_failed_next = 1'b0;
          byte_position_next  = 8'd0;
          elapsed_ticks_next  = 16'd0;
          res_next.command    = CMD_START;
          res_next_valid      = 1'b1;
        end
      end
      ACT_LOAD: begin
      end
      ACT_TICK: begin
        if (elapsed_ticks != 16'hFFFF) begin
          elapsed_ticks_next = elapsed_ticks + 16'd1;
        end
      end
      default: begin
        res_next_valid = 1'b1;
        case (phase)
          P_IDLE: res_next_valid = 1'b0;
          P_START: begin
            do_try = 1'b1; tp = P_ADDR_W; te = 16'd0;
          end
          P_RESTART: begin
            do_try = 1'b1; tp = P_ADDR_R; te = 16'd0;
          end
          P_READ: begin
            res_next.read_valid    = 1'b1;
            res_next.read_value    = item.bus_read_byte;
            res_next.read_position = byte_position;
            byte_position_next     = pos_inc;
            if (pos_inc < transfer_length) begin
              do_read = 1'b1;
            end else begin
              phase_next          = P_STOP;
              attempt_failed_next = 1'b0;
              res_next.command    = CMD_STOP;
            end
          end
          P_STOP: begin
            if (attempt_failed && attempts_left != 8'd0) begin
              attempts_left_next  = attempts_left - 8'd1;
              phase_next          = P_START;
              attempt_failed_next = 1'b0;
              byte_position_next  = 8'd0;
              elapsed_ticks_next  = 16'd0;
              res_next.command    = CMD_START;
            end else begin
              res_next.finished   = 1'b1;
              res_next.succeeded  = !attempt_failed;
              phase_next          = P_IDLE;
              attempt_failed_next = 1'b0;
            end
          end
          P_ADDR_W, P_CMD, P_REG_HI, P_REG_LO, P_DATA, P_ADDR_R: begin
            if (!item.ack_seen) begin
              do_try = 1'b1;
            end else begin
              te = 16'd0;
              case (phase)
                P_ADDR_W: begin
                  do_try = 1'b1;
                  if (current_kind == KIND_BLOCK16) begin
                    tp = P_CMD;
                  end else if (current_kind == KIND_WRITE8 || current_kind == KIND_READ8) begin
                    tp = P_REG_LO;
                  end else begin
                    tp = P_REG_HI;
                  end
                end
                P_CMD: begin
                  do_try = 1'b1; tp = P_REG_HI;
                end
                P_REG_HI: begin
                  do_try = 1'b1; tp = P_REG_LO;
                end
                P_REG_LO: begin
                  if (is_write) begin
                    byte_position_next = 8'd0;
                    if (transfer_length != 8'd0) begin
                      do_try = 1'b1; tp = P_DATA;
                    end else begin
                      phase_next          = P_STOP;
                      attempt_failed_next = 1'b0;
                      res_next.command    = CMD_STOP;
                    end
                  end else begin
                    phase_next       = P_RESTART;
                    res_next.command = CMD_START;
                  end
                end
                P_DATA: begin
                  byte_position_next = pos_inc;
                  if (pos_inc < transfer_length) begin
                    do_try = 1'b1; tp = P_DATA;
                  end else begin
                    phase_next          = P_STOP;
                    attempt_failed_next = 1'b0;
                    res_next.command    = CMD_STOP;
                  end
                end
                default: begin
                  byte_position_next = 8'd0;
                  do_read            = 1'b1;
                end
              endcase
            end
          end
          default: res_next_valid = 1'b0;
        endcase
      end
    endcase

    if (do_try) begin
      elapsed_ticks_next = te;
      if (te >= timeout_ticks) begin
        phase_next          = P_STOP;
        attempt_failed_next = 1'b1;
        res_next.command    = CMD_STOP;
      end else begin
        phase_next            = tp;
        res_next.command      = CMD_WRITE;
        res_next.command_byte = phase_byte(tp, target_address, target_register,
                                           block_read_command);
        res_from_buf_next     = (tp == P_DATA) &&
                                ({1'b0, byte_position_next} < 9'(BUFFER_DEPTH));
      end
    end

    if (do_read) begin
      phase_next = P_READ;
      res_next.command = (({1'b0, byte_position_next} + 9'd1) >= {1'b0, transfer_length}) ?
                         CMD_READ_NACK : CMD_READ_ACK;
    end
  end

  assign buf_wr_en = accept && item.action == ACT_LOAD &&
                     ({1'b0, item.load_index} < 9'(BUFFER_DEPTH));
  assign buf_rd_addr = accept ? byte_position_next[BUF_AW-1:0] : byte_position[BUF_AW-1:0];

  irts_wbuf u_wbuf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (item.load_index[BUF_AW-1:0]),
    .wr_data (item.load_byte),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks          <= TIMEOUT_RESET;
      retry_limit            <= RETRY_RESET;
      retry_limit_short_read <= RETRY_SHORT_RESET;
      block_read_command     <= BLOCK_CMD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_TIMEOUT:     timeout_ticks          <= pwdata[15:0];
        REG_RETRY:       retry_limit            <= pwdata[7:0];
        REG_RETRY_SHORT: retry_limit_short_read <= pwdata[7:0];
        REG_BLOCK_CMD:   block_read_command     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= P_IDLE;
      current_kind    <= '0;
      target_address  <= '0;
      target_register <= '0;
      transfer_length <= '0;
      byte_position   <= '0;
      attempts_left   <= '0;
      elapsed_ticks   <= '0;
      attempt_failed  <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        current_kind    <= current_kind_next;
        target_address  <= target_address_next;
        target_register <= target_register_next;
        transfer_length <= transfer_length_next;
        byte_position   <= byte_position_next;
        attempts_left   <= attempts_left_next;
        elapsed_ticks   <= elapsed_ticks_next;
        attempt_failed  <= attempt_failed_next;
        result_valid    <= res_next_valid;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_next_valid) begin
      res          <= res_next;
      res_from_buf <= res_from_buf_next;
    end
  end

  always_comb begin
    result = res;
    if (res_from_buf) begin
      result.command_byte = buf_q;
    end
  end

  `IRTS_ASSERT_NOW(a_finish_no_cmd, result_valid && result.finished, result.command == CMD_NONE, "finished result carries a bus command")
  `IRTS_ASSERT_NOW(a_read_cmd, result_valid && result.read_valid, result.command == CMD_READ_ACK || result.command == CMD_READ_NACK || result.command == CMD_STOP, "read data with wrong follow-up command")
  `IRTS_ASSERT_NEXT(a_tick_silent, accept && item.action == ACT_TICK, !result_valid, "tick produced a result")
  `IRTS_ASSERT_NEXT(a_idle_done_silent, accept && item.action == ACT_DONE && phase == P_IDLE, !result_valid && phase == P_IDLE, "done while idle changed state")

endmodule
`default_nettype wire

[test/i2c_register_transfer_sequencer_unit_tb.sv]
// Testbench for the I2C register transfer sequencer: directed and random transfers.
module i2c_register_transfer_sequencer_unit_tb;
  import irts_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_ITEMS = 160;
  localparam int REPORT_LINES = 30;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START, SQ_ADDR_W, SQ_CMD, SQ_REG_HI, SQ_REG_LO, SQ_DATA,
    SQ_RESTART, SQ_ADDR_R, SQ_READ, SQ_STOP
  } seq_state_t;

  class irts_scoreboard;
    logic [15:0] timeout_ticks;
    logic [7:0]  retry_limit;
    logic [7:0]  retry_limit_short;
    logic [7:0]  block_cmd;
    seq_state_t  state;
    logic [2:0]  kind;
    logic [6:0]  device;
    logic [15:0] reg_addr;
    logic [7:0]  length;
    logic [7:0]  position;
    logic [7:0]  attempts;
    logic [15:0] ticks;
    logic        failed;
    logic [7:0]  data_bytes [BUFFER_DEPTH];
    result_t     awaited_results [$];
    int          errors;
    int          work_items;

    function new();
      timeout_ticks = TIMEOUT_RESET;
      retry_limit = RETRY_RESET;
      retry_limit_short = RETRY_SHORT_RESET;
      block_cmd = BLOCK_CMD_RESET;
      state = SQ_IDLE;
      kind = '0;
      device = '0;
      reg_addr = '0;
      length = '0;
      position = '0;
      attempts = '0;
      ticks = '0;
      failed = 1'b0;
      errors = 0;
      work_items = 0;
      foreach (data_bytes[i]) data_bytes[i] = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_TIMEOUT: timeout_ticks = value[15:0];
        REG_RETRY: retry_limit = value[7:0];
        REG_RETRY_SHORT: retry_limit_short = value[7:0];
        default: block_cmd = value[7:0];
      endcase
    endfunction

    function result_t bus_op(logic [2:0] cmd, logic [7:0] data);
      result_t res;
      res = '0;
      res.command = cmd;
      res.command_byte = data;
      return res;
    endfunction

    function result_t stop_attempt(logic fail);
      failed = fail;
      state = SQ_STOP;
      return bus_op(CMD_STOP, 8'h00);
    endfunction

    function result_t write_current();
      logic [7:0] data;
      if (ticks >= timeout_ticks) return stop_attempt(1'b1);
      case (state)
        SQ_ADDR_W: data = {device, 1'b0};
        SQ_CMD: data = block_cmd;
        SQ_REG_HI: data = reg_addr[15:8];
        SQ_REG_LO: data = reg_addr[7:0];
        SQ_DATA: data = data_bytes[position];
        SQ_ADDR_R: data = {device, 1'b1};
        default: data = 8'h00;
      endcase
      return bus_op(CMD_WRITE, data);
    endfunction

    function result_t next_byte(seq_state_t s);
      state = s;
      ticks = '0;
      return write_current();
    endfunction

    function result_t read_byte();
      state = SQ_READ;
      if (int'(position) + 1 >= int'(length)) return bus_op(CMD_READ_NACK, 8'h00);
      return bus_op(CMD_READ_ACK, 8'h00);
    endfunction

    function result_t open_attempt();
      state = SQ_START;
      failed = 1'b0;
      position = '0;
      ticks = '0;
      return bus_op(CMD_START, 8'h00);
    endfunction

    function bit is_write();
      return kind == KIND_WRITE16 || kind == KIND_WRITE8;
    endfunction

    task note_item(item_t it);
      result_t res;
      bit produced;
      logic [7:0] slot;
      produced = 1'b1;
      res = '0;
      case (it.action)
        ACT_REQUEST: begin
          if (state != SQ_IDLE || it.transfer_kind > KIND_BLOCK16) begin
            produced = 1'b0;
          end else begin
            kind = it.transfer_kind;
            device = it.slave_address;
            reg_addr = it.register_address;
            length = it.byte_count;
            if (!is_write() && length == 0) length = 8'd1;
            attempts = (kind == KIND_READ8) ? retry_limit_short : retry_limit;
            res = open_attempt();
          end
        end
        ACT_LOAD: begin
          data_bytes[it.load_index] = it.load_byte;
          produced = 1'b0;
        end
        ACT_TICK: begin
          if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
          produced = 1'b0;
        end
        default: begin
          case (state)
            SQ_IDLE: produced = 1'b0;
            SQ_START: res = next_byte(SQ_ADDR_W);
            SQ_RESTART: res = next_byte(SQ_ADDR_R);
            SQ_READ: begin
              slot = position;
              position = position + 8'd1;
              if (position < length) res = read_byte();
              else res = stop_attempt(1'b0);
              res.read_valid = 1'b1;
              res.read_value = it.bus_read_byte;
              res.read_position = slot;
            end
            SQ_STOP: begin
              if (failed && attempts != 0) begin
                attempts = attempts - 8'd1;
                res = open_attempt();
              end else begin
                res = '0;
                res.finished = 1'b1;
                res.succeeded = !failed;
                state = SQ_IDLE;
                failed = 1'b0;
              end
            end
            default: begin
              if (!it.ack_seen) begin
                res = write_current();
              end else begin
                case (state)
                  SQ_ADDR_W: begin
                    if (kind == KIND_BLOCK16) res = next_byte(SQ_CMD);
                    else if (kind == KIND_WRITE8 || kind == KIND_READ8) res = next_byte(SQ_REG_LO);
                    else res = next_byte(SQ_REG_HI);
                  end
                  SQ_CMD: res = next_byte(SQ_REG_HI);
                  SQ_REG_HI: res = next_byte(SQ_REG_LO);
                  SQ_REG_LO: begin
                    if (is_write()) begin
                      position = '0;
                      if (length != 0) res = next_byte(SQ_DATA);
                      else res = stop_attempt(1'b0);
                    end else begin
                      state = SQ_RESTART;
                      res = bus_op(CMD_START, 8'h00);
                    end
                  end
                  SQ_DATA: begin
                    position = position + 8'd1;
                    if (position < length) res = next_byte(SQ_DATA);
                    else res = stop_attempt(1'b0);
                  end
                  default: begin
                    position = '0;
                    res = read_byte();
                  end
                endcase
              end
            end
          endcase
        end
      endcase
      if (produced) awaited_results.push_back(res);
      if (produced || it.action == ACT_LOAD || it.action == ACT_TICK) work_items++;
    endtask

    task report(string msg);
      if (errors < REPORT_LINES) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report("result transfer with nothing awaited");
        return;
      end
      want = awaited_results.pop_front();
      compare("command", 8'(got.command), 8'(want.command));
      compare("command_byte", got.command_byte, want.command_byte);
      compare("read_valid", 8'(got.read_valid), 8'(want.read_valid));
      compare("read_value", got.read_value, want.read_value);
      compare("read_position", got.read_position, want.read_position);
      compare("finished", 8'(got.finished), 8'(want.finished));
      compare("succeeded", 8'(got.succeeded), 8'(want.succeeded));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  irts_scoreboard sb;
  int cycles = 0;
  bit flaky;
  bit steady_in;

  i2c_register_transfer_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst && result_valid && !result_stall) begin
      sb.check_result(result);
    end
  end

  initial begin
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (hold > 0) begin
        hold--;
        result_stall = 1'b1;
      end else begin
        result_stall = 1'b0;
        if (!calm && $urandom_range(0, 99) < 25) begin
          hold = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic item_t noise();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t request_of(logic [2:0] kind, logic [6:0] dev, logic [15:0] ra,
                                       logic [7:0] cnt);
    item_t it;
    it = noise();
    it.action = ACT_REQUEST;
    it.transfer_kind = kind;
    it.slave_address = dev;
    it.register_address = ra;
    it.byte_count = cnt;
    return it;
  endfunction

  function automatic item_t done_of(logic ack, logic [7:0] rb);
    item_t it;
    it = noise();
    it.action = ACT_DONE;
    it.ack_seen = ack;
    it.bus_read_byte = rb;
    return it;
  endfunction

  function automatic item_t load_of(logic [7:0] idx, logic [7:0] data);
    item_t it;
    it = noise();
    it.action = ACT_LOAD;
    it.load_index = idx;
    it.load_byte = data;
    return it;
  endfunction

  function automatic int input_gap();
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) == 0) steady_in = !steady_in;
    if (steady_in || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send(item_t it);
    int gap;
    gap = input_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic make_item(output item_t it);
    int r;
    int sel;
    int ack_pct;
    int done_lim;
    logic [2:0] kind;
    logic [7:0] cnt;
    r = $urandom_range(0, 99);
    it = noise();
    if (sb.state == SQ_IDLE) begin
      if (r < 72) begin
        sel = $urandom_range(0, 99);
        if (sel < 2) cnt = 8'($urandom_range(100, 255));
        else if (sel < 20) cnt = 8'd0;
        else cnt = 8'($urandom_range(1, 6));
        if ($urandom_range(0, 19) == 0) kind = 3'($urandom_range(5, 7));
        else kind = 3'($urandom_range(0, 4));
        it = request_of(kind, it.slave_address, it.register_address, cnt);
        flaky = ($urandom_range(0, 99) < 30);
      end else if (r < 82) begin
        it.action = ACT_LOAD;
      end else if (r < 91) begin
        it.action = ACT_TICK;
      end else begin
        it.action = ACT_DONE;
      end
    end else begin
      ack_pct = flaky ? 50 : 95;
      done_lim = flaky ? 60 : 80;
      if (r < done_lim) it = done_of($urandom_range(0, 99) < ack_pct, it.bus_read_byte);
      else if (r < 90) it.action = ACT_TICK;
      else if (r < 95) it.action = ACT_LOAD;
      else it.action = ACT_REQUEST;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(logic [15:0] tmo, logic [7:0] retry, logic [7:0] retry_short,
                           logic [7:0] cmd);
    apb_write(REG_TIMEOUT, 32'(tmo));
    apb_write(REG_RETRY, 32'(retry));
    apb_write(REG_RETRY_SHORT, 32'(retry_short));
    apb_write(REG_BLOCK_CMD, 32'(cmd));
  endtask

  initial begin
    item_t it;
    int mark;
    sb = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    flaky = 1'b0;
    steady_in = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole write buffer so no transfer ever sends an unloaded byte
    for (int i = 0; i < BUFFER_DEPTH; i++) send(load_of(8'(i), 8'($urandom)));

    send(request_of(KIND_UNUSED, 7'h3C, 16'hA55A, 8'd3));
    send(done_of(1'b1, 8'hFF));
    send(request_of(KIND_WRITE8, 7'h7F, 16'hFFFF, 8'd0));
    send(done_of(1'b1, 8'h00));
    send(request_of(KIND_READ16, 7'h00, 16'h0000, 8'd1));
    send(done_of(1'b0, 8'h00));
    it = noise();
    it.action = ACT_TICK;
    send(it);
    for (int i = 0; i < 3; i++) send(done_of(1'b1, 8'h00));
    send(request_of(KIND_READ8, 7'h00, 16'h0000, 8'd0));
    for (int i = 0; i < 7; i++) send(done_of(1'b1, 8'hFF));
    send(request_of(KIND_BLOCK16, 7'h2A, 16'h8001, 8'd2));
    for (int i = 0; i < 10; i++) send(done_of(1'b1, 8'(i * 37)));

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: configure(16'd3, 8'd2, 8'd1, 8'hA5);
          2: configure(16'd0, 8'd0, 8'd0, 8'h00);
          3: configure(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
          4: configure(16'd2, 8'd1, 8'd3, 8'($urandom));
          default: configure(16'($urandom_range(0, 6)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 3)), 8'($urandom));
        endcase
      end
      mark = sb.work_items;
      while (sb.work_items < mark + PHASE_ITEMS) begin
        make_item(it);
        send(it);
      end
      // finish the open transfer so the registers can be changed
      while (sb.state != SQ_IDLE) send(done_of(1'b1, 8'($urandom)));
    end

    settle();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/irts_pkg.sv
hw/rtl/irts_wbuf.sv
hw/rtl/i2c_register_transfer_sequencer_unit.sv
test/i2c_register_transfer_sequencer_unit_tb.sv
